// ===== rtl/kcl_pkg.sv =====
`default_nettype none

package kcl_pkg;

  // field widths
  localparam int unsigned KeyW     = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CodeW    = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // reset values of the configuration registers
  localparam logic [CodeW-1:0]  PinCodeRst      = '0;
  localparam logic [CountW-1:0] PinLengthRst    = 4'd4;
  localparam logic [TimerW-1:0] TimeoutTicksRst = 16'd30000;
  localparam logic [CountW-1:0] FailureLimitRst = 4'd3;

  // saturation limits
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TimerW-1:0] TimerMax = '1;

  // item kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_KEY  = 1'b1
  } cmd_e;

  // verdict codes
  typedef enum logic [2:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_ACCEPT  = 3'd1,
    VERDICT_REJECT  = 3'd2,
    VERDICT_LOCKOUT = 3'd3,
    VERDICT_TIMEOUT = 3'd4
  } verdict_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIN_CODE      = 2'd0,
    CFG_PIN_LENGTH    = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2,
    CFG_FAILURE_LIMIT = 2'd3
  } cfg_idx_e;

  // one result transaction
  typedef struct packed {
    verdict_e          verdict;
    logic [CountW-1:0] digits;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/keypad_code_lock.sv =====
`default_nettype none

// Keypad code lock. Each input transaction is a time tick (cmd_i = 0) or a key
// press (cmd_i = 1, key_i nonzero; key 0 is ignored). Keys are collected until
// pin_length of them have arrived, then compared with pin_code (first key in
// the lowest byte) giving accept or reject; rejections count toward
// failure_limit, where lockout is reported and the count cleared. Ticks run an
// idle timer that every key restarts; reaching timeout_ticks reports a timeout
// and clears the entry and the failure count. Every input transaction yields
// exactly one result. State updates are combinational, so one transaction is
// taken per cycle while in_stall_o is low; results leave through an output
// register backed by a one-entry skid register, so in_stall_o rises only after
// the output side has stalled with both held. Configuration registers are to be
// written through cfg_we_i by the user only while idle; the block does not enforce it.
module keypad_code_lock #(
  parameter int unsigned MAX_CODE_KEYS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [kcl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [kcl_pkg::CfgDataW-1:0]     cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [kcl_pkg::KeyW-1:0]         key_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [2:0]                            verdict_o,
  output logic [kcl_pkg::CountW-1:0]            digits_entered_o
);

  localparam int unsigned IdxW = (MAX_CODE_KEYS > 1) ? $clog2(MAX_CODE_KEYS) : 1;
  localparam logic [kcl_pkg::CountW-1:0] MaxKeys = kcl_pkg::CountW'(MAX_CODE_KEYS);

  // configuration registers
  logic [kcl_pkg::CodeW-1:0]  pin_code_q;
  logic [kcl_pkg::CountW-1:0] pin_length_q;
  logic [kcl_pkg::TimerW-1:0] timeout_ticks_q;
  logic [kcl_pkg::CountW-1:0] failure_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_code_q      <= kcl_pkg::PinCodeRst;
      pin_length_q    <= kcl_pkg::PinLengthRst;
      timeout_ticks_q <= kcl_pkg::TimeoutTicksRst;
      failure_limit_q <= kcl_pkg::FailureLimitRst;
    end else if (cfg_we_i) begin
      case (kcl_pkg::cfg_idx_e'(cfg_index_i))
        kcl_pkg::CFG_PIN_CODE:      pin_code_q      <= cfg_data_i;
        kcl_pkg::CFG_PIN_LENGTH:    pin_length_q    <= cfg_data_i[kcl_pkg::CountW-1:0];
        kcl_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[kcl_pkg::TimerW-1:0];
        kcl_pkg::CFG_FAILURE_LIMIT: failure_limit_q <= cfg_data_i[kcl_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // lock state
  logic [kcl_pkg::KeyW-1:0]   keys_q [MAX_CODE_KEYS];
  logic [kcl_pkg::KeyW-1:0]   keys_d [MAX_CODE_KEYS];
  logic [kcl_pkg::CountW-1:0] entry_q, entry_d;
  logic [kcl_pkg::CountW-1:0] fail_q, fail_d;
  logic [kcl_pkg::TimerW-1:0] timer_q, timer_d;

  // output register and skid register
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  kcl_pkg::result_t out_q, out_d;
  kcl_pkg::result_t skid_q, skid_d;

  logic in_accept;
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  // effective code length, clamped to 1..MAX_CODE_KEYS
  logic [kcl_pkg::CountW-1:0] eff_len;
  always_comb begin
    eff_len = pin_length_q;
    if (eff_len == '0) eff_len = kcl_pkg::CountW'(1);
    if (eff_len > MaxKeys) eff_len = MaxKeys;
  end

  // key event decode
  logic key_event, tick_event;
  assign key_event  = in_accept && (kcl_pkg::cmd_e'(cmd_i) == kcl_pkg::CMD_KEY) &&
                      (key_i != '0);
  assign tick_event = in_accept && (kcl_pkg::cmd_e'(cmd_i) == kcl_pkg::CMD_TICK);

  // entry with the new key placed at the write position
  logic [IdxW-1:0]            wr_idx;
  logic [kcl_pkg::KeyW-1:0]   lane_key [MAX_CODE_KEYS];
  logic [MAX_CODE_KEYS-1:0]   lane_ok;
  logic [kcl_pkg::CountW-1:0] entry_inc;
  logic                       entry_full;
  logic                       code_match;

  assign wr_idx = entry_q[IdxW-1:0];

  always_comb begin
    for (int unsigned i = 0; i < MAX_CODE_KEYS; i++) begin
      lane_key[i] = (wr_idx == IdxW'(i)) ? key_i : keys_q[i];
      lane_ok[i]  = (kcl_pkg::CountW'(i) >= eff_len) ||
                    (lane_key[i] == pin_code_q[kcl_pkg::KeyW*i +: kcl_pkg::KeyW]);
    end
  end

  assign entry_inc  = (entry_q != kcl_pkg::CountMax) ? entry_q + 1'b1 : entry_q;
  assign entry_full = (entry_inc >= eff_len);
  assign code_match = &lane_ok;

  // saturating counters
  logic [kcl_pkg::TimerW-1:0] timer_inc;
  logic [kcl_pkg::CountW-1:0] fail_inc;
  assign timer_inc = (timer_q != kcl_pkg::TimerMax) ? timer_q + 1'b1 : timer_q;
  assign fail_inc  = (fail_q != kcl_pkg::CountMax) ? fail_q + 1'b1 : fail_q;

  // state update and verdict
  kcl_pkg::verdict_e verdict;
  always_comb begin
    keys_d  = keys_q;
    entry_d = entry_q;
    fail_d  = fail_q;
    timer_d = timer_q;
    verdict = kcl_pkg::VERDICT_NONE;
    if (tick_event) begin
      timer_d = timer_inc;
      if (timer_inc >= timeout_ticks_q) begin
        verdict = kcl_pkg::VERDICT_TIMEOUT;
        for (int unsigned i = 0; i < MAX_CODE_KEYS; i++) keys_d[i] = '0;
        entry_d = '0;
        fail_d  = '0;
        timer_d = '0;
      end
    end else if (key_event) begin
      timer_d = '0;
      if (entry_full) begin
        for (int unsigned i = 0; i < MAX_CODE_KEYS; i++) keys_d[i] = '0;
        entry_d = '0;
        if (code_match) begin
          verdict = kcl_pkg::VERDICT_ACCEPT;
        end else if (fail_inc >= failure_limit_q) begin
          verdict = kcl_pkg::VERDICT_LOCKOUT;
          fail_d  = '0;
        end else begin
          verdict = kcl_pkg::VERDICT_REJECT;
          fail_d  = fail_inc;
        end
      end else begin
        keys_d[wr_idx] = key_i;
        entry_d        = entry_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_CODE_KEYS; i++) keys_q[i] <= '0;
      entry_q <= '0;
      fail_q  <= '0;
      timer_q <= '0;
    end else begin
      keys_q  <= keys_d;
      entry_q <= entry_d;
      fail_q  <= fail_d;
      timer_q <= timer_d;
    end
  end

  // result steering between output and skid registers
  kcl_pkg::result_t new_res;
  assign new_res.verdict = verdict;
  assign new_res.digits  = entry_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_accept;
        out_d       = new_res;
      end
    end else if (in_accept) begin
      skid_valid_d = 1'b1;
      skid_d       = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = out_q.verdict;
  assign digits_entered_o = out_q.digits;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output register is empty");

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q < MaxKeys)
    else $error("entry count reached the code length bound");

  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.verdict != kcl_pkg::VERDICT_NONE) |-> (out_q.digits == '0))
    else $error("verdict reported with digits still held");

  a_key_restarts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_event |=> (timer_q == '0))
    else $error("key press did not restart the idle timer");

endmodule

`default_nettype wire
